// ===== rtl/countdown_timer_table_macros.svh =====
// Assertion helpers shared by the timer table RTL.
// Both macros sample on clk and stay quiet while rst_n is low.
`ifndef COUNTDOWN_TIMER_TABLE_MACROS_SVH
`define COUNTDOWN_TIMER_TABLE_MACROS_SVH

// Condition that must hold at every edge
`define CDT_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define CDT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/cdt_pkg.sv =====
package cdt_pkg;

    // Operation codes (s_axis_tuser)
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_DISARM = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Result kinds (m_axis_tuser)
    localparam logic [1:0] KIND_ARM_DONE    = 2'd0;
    localparam logic [1:0] KIND_DISARM_DONE = 2'd1;
    localparam logic [1:0] KIND_FIRED       = 2'd2;
    localparam logic [1:0] KIND_TICK_DONE   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_FULL       = 2'd1;
    localparam logic [1:0] STAT_NOT_ARMED  = 2'd2;

    // Stream word widths
    localparam int IN_TDATA_W  = 152;
    localparam int OUT_TDATA_W = 96;
    localparam int OP_W        = 2;
    localparam int KIND_W      = 2;
    localparam int TIME_W      = 64;
    localparam int TAG_W       = 16;
    localparam int SLOT_W      = 5;
    localparam int CNT_OUT_W   = 6;

    // One result word
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [1:0]           status;
        logic [SLOT_W-1:0]    slot;
        logic [TAG_W-1:0]     tag;
        logic                 moved;
        logic [CNT_OUT_W-1:0] count;
        logic [TIME_W-1:0]    mono;
        logic                 last;
    } res_t;

endpackage

// ===== rtl/cdt_satsub.sv =====
// Shared saturating subtractor: one wide subtract, borrow and zero detect
module cdt_satsub (
    input  logic [cdt_pkg::TIME_W-1:0] minuend,
    input  logic [cdt_pkg::TIME_W-1:0] subtrahend,
    output logic [cdt_pkg::TIME_W-1:0] diff,
    output logic                       zero
);
    import cdt_pkg::*;

    logic [TIME_W:0] wide;

    // borrow set means minuend < subtrahend
    assign wide = {1'b0, minuend} - {1'b0, subtrahend};
    assign zero = wide[TIME_W] || (wide[TIME_W-1:0] == '0);
    assign diff = zero ? '0 : wide[TIME_W-1:0];

endmodule

// ===== rtl/cdt_seq.sv =====
`include "countdown_timer_table_macros.svh"

// Sequencer: entry memories, fired flags, clock and result register
module cdt_seq #(
    parameter int MAX_TIMERS = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cdt_pkg::OP_W-1:0]      in_op,
    input  logic [cdt_pkg::TIME_W-1:0]    in_dur,
    input  logic [cdt_pkg::TAG_W-1:0]     in_tag,
    input  logic [cdt_pkg::SLOT_W-1:0]    in_slot,
    input  logic [cdt_pkg::TIME_W-1:0]    in_elapsed,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cdt_pkg::res_t                 out_res
);
    import cdt_pkg::*;

    localparam int CW = $clog2(MAX_TIMERS + 1);
    localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ARM   = 8'b0000_0010,
        ST_DCHK  = 8'b0000_0100,
        ST_DMOVE = 8'b0000_1000,
        ST_TREAD = 8'b0001_0000,
        ST_TCALC = 8'b0010_0000,
        ST_TEMIT = 8'b0100_0000,
        ST_TDONE = 8'b1000_0000
    } state_t;

    state_t                state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [TIME_W-1:0]     clock_reg, clock_next;
    logic [MAX_TIMERS-1:0] fired_reg, fired_next;
    logic                  out_valid_reg, out_valid_next;
    res_t                  out_res_reg, out_res_next;

    logic [TIME_W-1:0]     dur_reg, dur_next;
    logic [TW-1:0]         tag_reg, tag_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [TIME_W-1:0]     elapsed_reg, elapsed_next;

    // entry memories, undefined until written
    logic [TIME_W-1:0]     rem_mem [MAX_TIMERS];
    logic [TW-1:0]         tag_mem [MAX_TIMERS];
    logic [TIME_W-1:0]     rd_rem_reg;
    logic [TW-1:0]         rd_tag_reg;
    logic                  rd_en, rem_we, tag_we;
    logic [IW-1:0]         rd_addr, wr_addr;
    logic [TIME_W-1:0]     wr_rem;
    logic [TW-1:0]         wr_tag;

    logic [TIME_W-1:0]     sub_diff;
    logic                  sub_zero;
    logic                  out_free;
    logic                  slot_bad, slot_is_last;
    logic [CW-1:0]         last_slot;
    logic [IW-1:0]         slot_addr, idx_addr, cnt_addr, last_addr;

    function automatic res_t mk_res(
        input logic [KIND_W-1:0]    kind,
        input logic [1:0]           status,
        input logic [SLOT_W-1:0]    slot,
        input logic [TAG_W-1:0]     tag,
        input logic                 moved,
        input logic [CNT_OUT_W-1:0] count,
        input logic [TIME_W-1:0]    mono,
        input logic                 last
    );
        res_t r;
        r.kind   = kind;
        r.status = status;
        r.slot   = slot;
        r.tag    = tag;
        r.moved  = moved;
        r.count  = count;
        r.mono   = mono;
        r.last   = last;
        return r;
    endfunction

    cdt_satsub u_satsub (
        .minuend    (rd_rem_reg),
        .subtrahend (elapsed_reg),
        .diff       (sub_diff),
        .zero       (sub_zero)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign last_slot    = count_reg - CW'(1);
    assign slot_bad     = 7'(slot_reg) >= 7'(count_reg);
    assign slot_is_last = 7'(slot_reg) == 7'(last_slot);
    assign slot_addr    = IW'(slot_reg);
    assign idx_addr     = idx_reg[IW-1:0];
    assign cnt_addr     = count_reg[IW-1:0];
    assign last_addr    = last_slot[IW-1:0];

    // next-state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        clock_next     = clock_reg;
        fired_next     = fired_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        dur_next       = dur_reg;
        tag_next       = tag_reg;
        slot_next      = slot_reg;
        elapsed_next   = elapsed_reg;
        rd_en          = 1'b0;
        rd_addr        = idx_addr;
        rem_we         = 1'b0;
        tag_we         = 1'b0;
        wr_addr        = idx_addr;
        wr_rem         = sub_diff;
        wr_tag         = rd_tag_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dur_next     = in_dur;
                    tag_next     = in_tag[TW-1:0];
                    slot_next    = in_slot;
                    elapsed_next = in_elapsed;
                    case (in_op)
                        OP_ARM:    state_next = ST_ARM;
                        OP_DISARM: state_next = ST_DCHK;
                        OP_TICK:
                        begin
                            clock_next = clock_reg + in_elapsed;
                            idx_next   = '0;
                            state_next = ST_TREAD;
                        end
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end

            // append entry at the end of the table, or report a full table
            ST_ARM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (7'(count_reg) >= 7'(MAX_TIMERS))
                    begin
                        out_res_next = mk_res(KIND_ARM_DONE, STAT_FULL, '0, '0, 1'b0,
                                              CNT_OUT_W'(count_reg), clock_reg, 1'b1);
                    end
                    else
                    begin
                        rem_we               = 1'b1;
                        tag_we               = 1'b1;
                        wr_addr              = cnt_addr;
                        wr_rem               = dur_reg;
                        wr_tag               = tag_reg;
                        fired_next[cnt_addr] = 1'b0;
                        count_next           = count_reg + CW'(1);
                        out_res_next = mk_res(KIND_ARM_DONE, STAT_OK, SLOT_W'(count_reg),
                                              TAG_W'(tag_reg), 1'b0,
                                              CNT_OUT_W'(count_next), clock_reg, 1'b1);
                    end
                end
            end

            // range check; fetch last entry when it has to move
            ST_DCHK:
            begin
                if (slot_bad)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = mk_res(KIND_DISARM_DONE, STAT_NOT_ARMED, slot_reg,
                                                '0, 1'b0, CNT_OUT_W'(count_reg),
                                                clock_reg, 1'b1);
                        state_next     = ST_IDLE;
                    end
                end
                else if (slot_is_last)
                begin
                    if (out_free)
                    begin
                        count_next     = last_slot;
                        out_valid_next = 1'b1;
                        out_res_next   = mk_res(KIND_DISARM_DONE, STAT_OK, slot_reg, '0,
                                                1'b0, CNT_OUT_W'(last_slot), clock_reg,
                                                1'b1);
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = last_addr;
                    state_next = ST_DMOVE;
                end
            end

            // write the last entry into the freed slot
            ST_DMOVE:
            begin
                if (out_free)
                begin
                    rem_we                = 1'b1;
                    tag_we                = 1'b1;
                    wr_addr               = slot_addr;
                    wr_rem                = rd_rem_reg;
                    wr_tag                = rd_tag_reg;
                    fired_next[slot_addr] = fired_reg[last_addr];
                    count_next            = last_slot;
                    out_valid_next        = 1'b1;
                    out_res_next          = mk_res(KIND_DISARM_DONE, STAT_OK, slot_reg,
                                                   TAG_W'(rd_tag_reg), 1'b1,
                                                   CNT_OUT_W'(last_slot), clock_reg, 1'b1);
                    state_next            = ST_IDLE;
                end
            end

            // walk the table, skipping fired entries
            ST_TREAD:
            begin
                if (idx_reg >= count_reg)
                begin
                    state_next = ST_TDONE;
                end
                else if (fired_reg[idx_addr])
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_addr;
                    state_next = ST_TCALC;
                end
            end

            // saturating subtract and write back
            ST_TCALC:
            begin
                rem_we  = 1'b1;
                wr_addr = idx_addr;
                wr_rem  = sub_diff;
                if (sub_zero)
                begin
                    fired_next[idx_addr] = 1'b1;
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_res_next   = mk_res(KIND_FIRED, STAT_OK, SLOT_W'(idx_reg),
                                                TAG_W'(rd_tag_reg), 1'b0,
                                                CNT_OUT_W'(count_reg), clock_reg, 1'b0);
                        idx_next       = idx_reg + CW'(1);
                        state_next     = ST_TREAD;
                    end
                    else
                    begin
                        state_next = ST_TEMIT;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_TREAD;
                end
            end

            // fired word waiting for the output register
            ST_TEMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = mk_res(KIND_FIRED, STAT_OK, SLOT_W'(idx_reg),
                                            TAG_W'(rd_tag_reg), 1'b0,
                                            CNT_OUT_W'(count_reg), clock_reg, 1'b0);
                    idx_next       = idx_reg + CW'(1);
                    state_next     = ST_TREAD;
                end
            end

            ST_TDONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = mk_res(KIND_TICK_DONE, STAT_OK, '0, '0, 1'b0,
                                            CNT_OUT_W'(count_reg), clock_reg, 1'b1);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            clock_reg     <= '0;
            fired_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            clock_reg     <= clock_next;
            fired_reg     <= fired_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
        dur_reg     <= dur_next;
        tag_reg     <= tag_next;
        slot_reg    <= slot_next;
        elapsed_reg <= elapsed_next;
    end

    // entry memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (rem_we)
        begin
            rem_mem[wr_addr] <= wr_rem;
        end
        if (tag_we)
        begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (rd_en)
        begin
            rd_rem_reg <= rem_mem[rd_addr];
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    `CDT_ASSERT_ALWAYS(a_count_max, 7'(count_reg) <= 7'(MAX_TIMERS), "entry count over table size")
    `CDT_ASSERT_IMPL(a_calc_after_read, state_reg == ST_TCALC, $past(state_reg) == ST_TREAD, "subtract without a read")
    `CDT_ASSERT_IMPL(a_fired_not_last, out_valid_reg && (out_res_reg.kind == KIND_FIRED), !out_res_reg.last, "fired word marked last")
    `CDT_ASSERT_IMPL(a_emit_flag_set, state_reg == ST_TEMIT, fired_reg[idx_addr], "pending fire without flag")

endmodule

// ===== rtl/countdown_timer_table.sv =====
// Arm passes through the ARM state to the result register; disarm through DCHK, and DMOVE when an entry moves.
// Tick: TREAD and TCALC for each unfired armed entry, TREAD alone for an already fired entry, then TDONE.
// One item at a time; a tick walks the table through the single read port of the entry memory
// and the shared saturating subtractor, and a new item is accepted only back in the idle state.
// Reset (rst_n low, asynchronous): table empty, fired flags and clock cleared, output idle.
module countdown_timer_table #(
    parameter int MAX_TIMERS = 32,
    parameter int TAG_BITS   = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // duration_ns[63:0], timer_tag[79:64], slot_index[84:80], elapsed_ns[148:85], zero pad
    input  logic [cdt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // operation[1:0]
    input  logic [cdt_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status[1:0], slot_out[6:2], tag_out[22:7], moved_valid[23], active_count[29:24],
    // monotonic_ns[93:30], zero pad
    output logic [cdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // kind[1:0]
    output logic [cdt_pkg::KIND_W-1:0]        m_axis_tuser,
    output logic                              m_axis_tlast
);
    import cdt_pkg::*;

    res_t res;

    cdt_seq #(
        .MAX_TIMERS (MAX_TIMERS),
        .TAG_BITS   (TAG_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (s_axis_tuser),
        .in_dur     (s_axis_tdata[63:0]),
        .in_tag     (s_axis_tdata[79:64]),
        .in_slot    (s_axis_tdata[84:80]),
        .in_elapsed (s_axis_tdata[148:85]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (res)
    );

    // pack the result word
    assign m_axis_tdata = {2'b00, res.mono, res.count, res.moved, res.tag, res.slot, res.status};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule

// ===== verif/tb_countdown_timer_table.sv =====
`timescale 1ns / 100ps

module tb_countdown_timer_table;

    import cdt_pkg::*;

    localparam int SLOTS       = 32;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 100;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_OPS  = 110;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    // Shadow copy of the timer table
    logic [TIME_W-1:0] tmr_remaining [SLOTS];
    logic [TAG_W-1:0]  tmr_tag       [SLOTS];
    logic              tmr_fired     [SLOTS];
    int                armed_cnt;
    logic [TIME_W-1:0] mono_ns;

    res_t pending_results [$];

    int error_count;
    int cycle_count;
    bit tx_idle_en;
    bit rx_idle_en;
    bit rx_hold_req;

    countdown_timer_table #(
        .MAX_TIMERS (SLOTS),
        .TAG_BITS   (16)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_error(input string msg);
        error_count++;
        if (error_count <= 60)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic void push_result(input logic [1:0] kind, input logic [1:0] status,
                                        input logic [4:0] slot, input logic [15:0] tag,
                                        input logic moved, input logic last);
        res_t r;
        r.kind   = kind;
        r.status = status;
        r.slot   = slot;
        r.tag    = tag;
        r.moved  = moved;
        r.count  = 6'(armed_cnt);
        r.mono   = mono_ns;
        r.last   = last;
        pending_results.push_back(r);
    endfunction

    // Update the shadow table for one accepted word and queue what it yields
    function automatic void predict_timer_results(input logic [1:0] op,
                                                  input logic [63:0] dur,
                                                  input logic [15:0] tag,
                                                  input logic [4:0] slot,
                                                  input logic [63:0] elapsed);
        int last_slot;
        case (op)
            OP_ARM:
            begin
                if (armed_cnt >= SLOTS)
                begin
                    push_result(KIND_ARM_DONE, STAT_FULL, 5'd0, 16'd0, 1'b0, 1'b1);
                end
                else
                begin
                    tmr_remaining[5'(armed_cnt)] = dur;
                    tmr_tag[5'(armed_cnt)]       = tag;
                    tmr_fired[5'(armed_cnt)]     = 1'b0;
                    armed_cnt++;
                    push_result(KIND_ARM_DONE, STAT_OK, 5'(armed_cnt - 1), tag, 1'b0, 1'b1);
                end
            end
            OP_DISARM:
            begin
                if (int'(slot) >= armed_cnt)
                begin
                    push_result(KIND_DISARM_DONE, STAT_NOT_ARMED, slot, 16'd0, 1'b0, 1'b1);
                end
                else
                begin
                    last_slot = armed_cnt - 1;
                    armed_cnt = last_slot;
                    if (int'(slot) != last_slot)
                    begin
                        // last entry, fired flag included, fills the hole
                        tmr_remaining[slot] = tmr_remaining[5'(last_slot)];
                        tmr_tag[slot]       = tmr_tag[5'(last_slot)];
                        tmr_fired[slot]     = tmr_fired[5'(last_slot)];
                        push_result(KIND_DISARM_DONE, STAT_OK, slot, tmr_tag[slot], 1'b1, 1'b1);
                    end
                    else
                    begin
                        push_result(KIND_DISARM_DONE, STAT_OK, slot, 16'd0, 1'b0, 1'b1);
                    end
                end
            end
            OP_TICK:
            begin
                mono_ns = mono_ns + elapsed;
                for (int i = 0; i < armed_cnt; i++)
                begin
                    if (!tmr_fired[5'(i)])
                    begin
                        tmr_remaining[5'(i)] = (tmr_remaining[5'(i)] > elapsed) ?
                                               tmr_remaining[5'(i)] - elapsed : 64'd0;
                        if (tmr_remaining[5'(i)] == 64'd0)
                        begin
                            tmr_fired[5'(i)] = 1'b1;
                            push_result(KIND_FIRED, STAT_OK, 5'(i), tmr_tag[5'(i)], 1'b0, 1'b0);
                        end
                    end
                end
                push_result(KIND_TICK_DONE, STAT_OK, 5'd0, 16'd0, 1'b0, 1'b1);
            end
            default: ; // unknown operation: dropped, nothing comes back
        endcase
    endfunction

    // Offer one input word, after a random gap when tx_idle_en is set; predict once accepted
    task automatic send_word(input logic [1:0] op, input logic [63:0] dur,
                             input logic [15:0] tag, input logic [4:0] slot,
                             input logic [63:0] elapsed);
        int gap;
        gap = tx_idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, elapsed, slot, tag, dur};
        do @(posedge clk); while (!s_axis_tready);
        predict_timer_results(op, dur, tag, slot, elapsed);
    endtask

    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_ns(input int big_pct, input int span);
        if ($urandom_range(0, 99) < big_pct)
            return {$urandom, $urandom};
        return 64'($urandom_range(0, span));
    endfunction

    // Extremes, every operation and the corner cases on a short table
    task automatic test_directed();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        send_word(OP_ARM, 64'd0, 16'h0000, 5'd0, 64'd0);
        send_word(OP_ARM, '1, 16'hFFFF, 5'd0, 64'd0);
        send_word(OP_ARM, 64'd5, 16'h1234, 5'd0, 64'd0);
        // zero duration fires on a zero-length tick
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd0);
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd3);
        // already fired entry is skipped
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd0);
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd31, 64'd0);
        // remove slot 0, last entry moves in
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd0, 64'd0);
        // remove the last entry, nothing moves
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd1, 64'd0);
        send_word(OP_UNUSED, '1, 16'hFFFF, 5'd31, '1);
        // max elapsed: saturates and wraps the clock
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, '1);
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd0, 64'd0);
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd0, 64'd0);
        send_word(OP_ARM, 64'd1, 16'hA5A5, 5'd0, 64'd0);
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd1);
        send_word(OP_DISARM, 64'd0, 16'd0, 5'd0, 64'd0);
    endtask

    // Fill the table while the receiver holds off, then fire every entry at once
    task automatic test_full_table_backpressure();
        tx_idle_en  = 1'b0;
        rx_idle_en  = 1'b0;
        rx_hold_req = 1'b1;
        while (armed_cnt < SLOTS)
            send_word(OP_ARM, 64'($urandom_range(1, 50)), 16'($urandom), 5'($urandom), 64'd0);
        send_word(OP_ARM, 64'd7, 16'($urandom), 5'd0, 64'd0);
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd100);
        // sender pauses until the whole burst is out
        wait_all_results();
        // fired entries now get shuffled around by disarm
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        repeat (16)
            send_word(OP_DISARM, 64'd0, 16'd0, 5'($urandom_range(0, armed_cnt - 1)), 64'd0);
        send_word(OP_TICK, 64'd0, 16'd0, 5'd0, 64'd1000);
    endtask

    // Random mix of arm, disarm, tick and unused operations with random content in every field
    task automatic test_random_mix();
        int n;
        int pick;
        logic [1:0]  op;
        logic [63:0] dur;
        logic [63:0] elapsed;
        logic [4:0]  slot;
        n = 0;
        while (n < RANDOM_OPS)
        begin
            if (n % 30 == 0)
            begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            pick    = $urandom_range(0, 99);
            dur     = {$urandom, $urandom};
            elapsed = {$urandom, $urandom};
            slot    = 5'($urandom);
            if (pick < 5)
            begin
                op = OP_UNUSED;
            end
            else if (pick < 45)
            begin
                op  = OP_ARM;
                dur = rand_ns(10, 3000);
            end
            else if (pick < 70)
            begin
                op = OP_DISARM;
                if (armed_cnt > 0 && $urandom_range(0, 9) != 0)
                    slot = 5'($urandom_range(0, armed_cnt - 1));
            end
            else
            begin
                op      = OP_TICK;
                elapsed = rand_ns(5, 400);
            end
            send_word(op, dur, 16'($urandom), slot, elapsed);
            if (op != OP_UNUSED)
                n++;
        end
    endtask

    // Receiver ready: random stalls per word, or one long hold on request
    initial
    begin : rx_ready
        int stall_left;
        stall_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                stall_left  = HOLD_CYCLES;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                stall_left = rx_idle_en ? $urandom_range(0, 9) : 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            m_axis_tready <= (stall_left == 0);
        end
    end

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    // Compare every accepted result word with the oldest prediction
    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result with nothing pending, kind %0d", m_axis_tuser));
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 64'(m_axis_tuser), 64'(want.kind));
                check_field("status", 64'(m_axis_tdata[1:0]), 64'(want.status));
                check_field("slot_out", 64'(m_axis_tdata[6:2]), 64'(want.slot));
                check_field("tag_out", 64'(m_axis_tdata[22:7]), 64'(want.tag));
                check_field("moved_valid", 64'(m_axis_tdata[23]), 64'(want.moved));
                check_field("active_count", 64'(m_axis_tdata[29:24]), 64'(want.count));
                check_field("monotonic_ns", m_axis_tdata[93:30], want.mono);
                check_field("tdata pad", 64'(m_axis_tdata[95:94]), 64'd0);
                check_field("tlast", 64'(m_axis_tlast), 64'(want.last));
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : main
        rst_n         = 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        error_count   = 0;
        armed_cnt     = 0;
        mono_ns       = '0;
        rx_hold_req   = 1'b0;
        tx_idle_en    = 1'b0;
        rx_idle_en    = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            tmr_remaining[5'(i)] = '0;
            tmr_tag[5'(i)]       = '0;
            tmr_fired[5'(i)]     = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table_backpressure();
        test_random_mix();

        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
